@@ rtl/wlem_pkg.sv @@
// Shared constants and types for the window local extremum map block.
// No dependencies; compile before the interfaces and the core.
package wlem_pkg;

  localparam int unsigned MaxLineLength = 1024;
  localparam int unsigned SampleWidth   = 16;

  // line store address, effective line length (holds MaxLineLength itself)
  localparam int unsigned AddrWidth = $clog2(MaxLineLength);
  localparam int unsigned LenWidth  = AddrWidth + 1;
  // line count register and line counter (runs a little past the count)
  localparam int unsigned CntWidth  = 16;
  localparam int unsigned ColWidth  = CntWidth + 1;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] CfgLineLength = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgLineCount  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgFindMinima = 2'd2;

  // item kinds
  localparam logic KindSample = 1'b0;
  localparam logic KindDrain  = 1'b1;

  typedef logic signed [SampleWidth-1:0] sample_t;

  // one stream row of the window: line c-2, line c-1, line c
  typedef struct packed {
    sample_t older;
    sample_t newer;
    sample_t latest;
  } win_row_t;

endpackage

@@ rtl/wlem_if.sv @@
// Handshake channels of the window local extremum map block: pixel input,
// result output and configuration write. Depends on wlem_pkg.
interface wlem_in_if import wlem_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    kind;
  sample_t sample;

  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface wlem_out_if;
  logic valid;
  logic ready;
  logic is_extreme;
  logic last;

  modport source (output valid, output is_extreme, output last, input ready);
  modport sink   (input valid, input is_extreme, input last, output ready);
endinterface

interface wlem_cfg_if import wlem_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CfgIdxWidth-1:0]  index;
  logic [CfgDataWidth-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/window_local_extremum_map_core.sv @@
// 3x3 local extremum detector over a streamed image, with two line stores.
// Depends on wlem_pkg and the channels in wlem_if.sv.

// Pixels arrive line after line (line_length samples per line, line_count
// lines per image); each request on pix_i carries either a sample or a drain
// tick. For every pixel one flag leaves on res_o, set when none of the
// existing eight neighbors is strictly greater (strictly smaller with
// find_minima set); neighbors outside the image are ignored and equal
// neighbors never disqualify. A pixel's flag leaves one line plus one sample
// after the pixel itself, so after the last sample the source sends drain
// ticks, one per pending flag; the flag of the image's final pixel carries
// last. Early drain ticks, samples beyond a full image and drains after the
// final flag are accepted and dropped. The block takes one request per clock:
// each request reads both line stores at its row (the read is prefetched
// from row_d, so the single read port never stalls) and updates the window,
// the stores and the result register in the same cycle. pix_i.ready drops
// only while the result register is full and not taken, and for exactly one
// cycle after the last sample of a single-line image, when the window makes
// one internal step to line the flags up. Configuration is taken at any time
// (cfg_i.ready is tied high) but must only change while the block is idle
// between images; the block then runs until reset, which clears the counters.
// Line length (data[10:0]) 0 acts as 1, above 1024 as 1024; line count 0 as 1.
module window_local_extremum_map_core import wlem_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  wlem_cfg_if.sink      cfg_i,
  wlem_in_if.sink       pix_i,
  wlem_out_if.source    res_o
);

  // configuration, held in effective form
  logic [LenWidth-1:0] len_q;
  logic [CntWidth-1:0] cnt_q;
  logic                minima_q;

  // stream position (row within line, line) and output position
  logic [AddrWidth-1:0] row_q, row_d;
  logic [ColWidth-1:0]  col_q, col_d;
  logic [AddrWidth-1:0] orow_q, orow_d;
  logic [CntWidth-1:0]  ocol_q, ocol_d;

  // line stores and their prefetched read data
  sample_t older_mem [MaxLineLength];
  sample_t newer_mem [MaxLineLength];
  sample_t rd_old_q, rd_new_q;
  logic [AddrWidth-1:0] rd_addr;
  logic                 fwd;

  // window rows: w1 one row back, w2 the current row
  win_row_t w0_q, w1_q, w2_q;
  win_row_t down_row;

  // result register
  logic res_valid_q, res_extreme_q, res_last_q;

  logic       accept, in_phase, out_done, auto_go;
  logic       adv, have, emit, extreme, is_last;
  logic       up_en, down_en, left_en, right_en;
  sample_t    key;
  logic [LenWidth-1:0] row_inc, orow_inc;
  logic [LenWidth-1:0] cfg_len;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_len = cfg_i.data[LenWidth-1:0];
    if (cfg_len == '0) begin
      cfg_len = LenWidth'(1);
    end else if (cfg_len > LenWidth'(MaxLineLength)) begin
      cfg_len = LenWidth'(MaxLineLength);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LenWidth'(MaxLineLength);
      cnt_q    <= CntWidth'(1024);
      minima_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgLineLength: len_q <= cfg_len;
        CfgLineCount: begin
          cnt_q <= (cfg_i.data[CntWidth-1:0] == '0) ? CntWidth'(1)
                                                   : cfg_i.data[CntWidth-1:0];
        end
        CfgFindMinima: minima_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // request control
  // ---------------------------------------------------------------------
  assign in_phase = col_q < {1'b0, cnt_q};
  assign out_done = ocol_q >= cnt_q;

  // single-line image: after its last sample the first position past the
  // image yields no flag, so step over it on our own
  assign auto_go = !in_phase && (row_q == '0) && (col_q < ColWidth'(2)) && !out_done;

  assign pix_i.ready = (!res_valid_q || res_o.ready) && !auto_go;
  assign accept      = pix_i.valid && pix_i.ready;

  // advance on in-image samples, on drains once the image is in, and on the
  // internal step; drop everything else
  assign adv = (accept && (pix_i.kind == KindSample) && in_phase)
            || (accept && (pix_i.kind == KindDrain) && !in_phase && !out_done)
            || auto_go;

  assign key = (accept && (pix_i.kind == KindSample)) ? pix_i.sample : '0;

  assign row_inc = {1'b0, row_q} + LenWidth'(1);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (adv) begin
      if (row_inc == len_q) begin
        row_d = '0;
        col_d = col_q + ColWidth'(1);
      end else begin
        row_d = row_inc[AddrWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ---------------------------------------------------------------------
  // line stores: write the current row, prefetch the next one
  // ---------------------------------------------------------------------
  assign rd_addr = row_d;
  assign fwd     = adv && (rd_addr == row_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      older_mem[row_q] <= rd_new_q;
      newer_mem[row_q] <= key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fwd) begin
      rd_old_q <= rd_new_q;
      rd_new_q <= key;
    end else begin
      rd_old_q <= older_mem[rd_addr];
      rd_new_q <= newer_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------
  // window and judgment
  // ---------------------------------------------------------------------
  assign down_row = '{older: rd_old_q, newer: rd_new_q, latest: key};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w0_q <= w1_q;
      w1_q <= w2_q;
      w2_q <= down_row;
    end
  end

  // On the first row of a line the pixel judged is the previous line's last
  // row, taken before the shift (center w2.newer, no row below). Otherwise
  // it is the previous row, which also sits at w2 before the shift, with the
  // incoming row below.
  always_comb begin
    if (row_q == '0) begin
      have     = col_q >= ColWidth'(2);
      up_en    = len_q != LenWidth'(1);
      down_en  = 1'b0;
      left_en  = col_q >= ColWidth'(3);
      right_en = col_q <= {1'b0, cnt_q};
    end else begin
      have     = col_q >= ColWidth'(1);
      up_en    = row_q >= AddrWidth'(2);
      down_en  = 1'b1;
      left_en  = col_q >= ColWidth'(2);
      right_en = in_phase;
    end
  end

  always_comb begin
    sample_t nb [8];
    logic    en [8];
    sample_t center;
    center = w2_q.newer;
    nb[0] = w1_q.older;     en[0] = up_en & left_en;
    nb[1] = w1_q.newer;     en[1] = up_en;
    nb[2] = w1_q.latest;    en[2] = up_en & right_en;
    nb[3] = w2_q.older;     en[3] = left_en;
    nb[4] = w2_q.latest;    en[4] = right_en;
    nb[5] = down_row.older; en[5] = down_en & left_en;
    nb[6] = down_row.newer; en[6] = down_en;
    nb[7] = down_row.latest; en[7] = down_en & right_en;
    extreme = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (en[i] && (minima_q ? (nb[i] < center) : (nb[i] > center))) begin
        extreme = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // output position and result register
  // ---------------------------------------------------------------------
  assign emit     = adv && have && !out_done;
  assign orow_inc = {1'b0, orow_q} + LenWidth'(1);
  assign is_last  = (ocol_q == cnt_q - CntWidth'(1)) && (orow_inc == len_q);

  always_comb begin
    orow_d = orow_q;
    ocol_d = ocol_q;
    if (emit) begin
      if (orow_inc == len_q) begin
        orow_d = '0;
        ocol_d = ocol_q + CntWidth'(1);
      end else begin
        orow_d = orow_inc[AddrWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orow_q      <= '0;
      ocol_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      orow_q <= orow_d;
      ocol_q <= ocol_d;
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // hold the flag until taken; load only when a request produced one
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_extreme_q <= extreme;
      res_last_q    <= is_last;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.is_extreme = res_extreme_q;
  assign res_o.last       = res_last_q;

endmodule

@@ tb/window_local_extremum_map_core_tb.sv @@
// Self-checking testbench for window_local_extremum_map_core: streams one image,
// predicts every 3x3 extremum flag and compares the results one by one.
// Depends on wlem_pkg, the channels in wlem_if.sv and the core itself.
module window_local_extremum_map_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wlem_pkg::*;

  // One flag as it leaves on the result channel
  typedef struct packed {
    logic is_extreme;
    logic last;
  } flag_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wlem_cfg_if cfg_if ();
  wlem_in_if  pix_if ();
  wlem_out_if res_if ();

  window_local_extremum_map_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if.sink),
    .pix_i  (pix_if.sink),
    .res_o  (res_if.source)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: register copies, two previous lines, the 3x3 tile
  // (row = stream position, column = line), and both stream counters.
  logic [LenWidth-1:0] cfg_len = LenWidth'(1024);
  logic [CntWidth-1:0] cfg_cnt = CntWidth'(1024);
  logic                cfg_min = 1'b0;
  sample_t             prev2_line [MaxLineLength];
  sample_t             prev1_line [MaxLineLength];
  sample_t             tile [3][3];
  int unsigned         stream_pos = 0;
  int unsigned         flags_out  = 0;

  // Flags predicted but not yet seen on the result channel, oldest first
  flag_t pending_flags [$];
  flag_t oldest_flag;
  int    mismatches = 0;

  // Knobs set by the stimulus; res_idle_on and rx_hold steer the result sink
  bit          pix_idle_on = 1'b1;
  bit          res_idle_on = 1'b1;
  int unsigned rx_hold = 0;

  // Zero geometry acts as 1, oversize line length clamps to the store depth
  function automatic int unsigned line_len();
    if (cfg_len == 0) return 1;
    if (cfg_len > MaxLineLength) return MaxLineLength;
    return 32'(cfg_len);
  endfunction

  function automatic int unsigned image_size();
    int unsigned cnt;
    cnt = (cfg_cnt == 0) ? 1 : 32'(cfg_cnt);
    return line_len() * cnt;
  endfunction

  // True when no neighbor that is enabled beats the center of tile row cr.
  // up/down run along the line, left/right across lines.
  function automatic bit no_rival(int cr, bit up, bit down, bit left, bit right);
    sample_t center;
    sample_t other;
    int      rr;
    center = tile[cr][1];
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = cr + dr;
        if (dr == 0 && dc == 0) continue;
        if ((dr < 0 && !up) || (dr > 0 && !down)) continue;
        if ((dc < 0 && !left) || (dc > 0 && !right)) continue;
        if (rr < 0 || rr > 2) continue;
        other = tile[rr][1 + dc];
        if (cfg_min ? (other < center) : (other > center)) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Advance the window by one stream position and report a flag if one is due
  task automatic step_window(sample_t pix, output bit got, output flag_t res);
    int unsigned len;
    int unsigned total;
    int unsigned cnt;
    int unsigned c;
    int unsigned r;
    bit          have;
    bit          flag;
    sample_t     a;
    sample_t     b;
    len   = line_len();
    total = image_size();
    cnt   = total / len;
    c     = stream_pos / len;
    r     = stream_pos % len;
    have  = 1'b0;
    flag  = 1'b0;
    got   = 1'b0;
    res   = '0;
    stream_pos++;
    // last pixel of the line before last: its lower neighbor never exists
    if (r == 0 && c >= 2) begin
      flag = no_rival(2, len >= 2, 1'b0, c >= 3, (c - 1) < cnt);
      have = 1'b1;
    end
    a = prev2_line[r];
    b = prev1_line[r];
    prev2_line[r] = b;
    prev1_line[r] = pix;
    for (int k = 0; k < 3; k++) begin
      tile[0][k] = tile[1][k];
      tile[1][k] = tile[2][k];
    end
    tile[2][0] = a;
    tile[2][1] = b;
    tile[2][2] = pix;
    if (r >= 1 && c >= 1) begin
      flag = no_rival(1, r >= 2, 1'b1, c >= 2, c < cnt);
      have = 1'b1;
    end
    if (have && flags_out < total) begin
      got            = 1'b1;
      res.is_extreme = flag;
      res.last       = (flags_out == total - 1);
      flags_out++;
    end
  endtask

  // Work out what one accepted request yields and queue it
  task automatic predict_request(logic kind, sample_t pix);
    bit    got;
    flag_t res;
    got = 1'b0;
    if (kind == KindSample) begin
      // drop samples beyond a full image
      if (stream_pos < image_size()) step_window(pix, got, res);
    end else if (stream_pos >= image_size() && flags_out < image_size()) begin
      // a single-line image needs one silent step to line the flags up
      step_window('0, got, res);
      if (!got && flags_out < image_size()) step_window('0, got, res);
    end
    if (got) pending_flags.push_back(res);
  endtask

  // Mix of plateaus (small range, many ties), full-range values and extremes
  function automatic sample_t random_pixel();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return sample_t'(int'($urandom_range(0, 4)) - 2);
    if (roll == 8) return 16'sh7fff;
    if (roll == 9) return 16'sh8000;
    return sample_t'($urandom());
  endfunction

  // Offer one request, hold it until taken, then maybe idle for a burst.
  // Valid stays high unless idled, so back-to-back requests need one assignment.
  task automatic send_request(logic kind, sample_t pix);
    pix_if.valid  <= 1'b1;
    pix_if.kind   <= kind;
    pix_if.sample <= pix;
    do @(posedge clk_i); while (!pix_if.ready);
    predict_request(kind, pix);
    if (pix_idle_on && $urandom_range(0, 5) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic write_register(logic [CfgIdxWidth-1:0] index,
                                logic [CfgDataWidth-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (index)
      CfgLineLength: cfg_len = value[LenWidth-1:0];
      CfgLineCount:  cfg_cnt = value[CntWidth-1:0];
      CfgFindMinima: cfg_min = value[0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, wait for every predicted flag, then let the pipe settle
  task automatic settle_stream(int unsigned tail);
    pix_if.valid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // The block runs a single image per reset, so pick its shape per seed:
  // mostly short-line multi-line images, sometimes a one-sample line (written
  // as 0 or 1), a single line (line count 0 or 1), or a long line.
  task automatic test_configure_image();
    int unsigned          pick;
    logic [LenWidth-1:0]  len_w;
    logic [CntWidth-1:0]  cnt_w;
    pick = $urandom_range(0, 7);
    case (pick)
      5: begin
        len_w = LenWidth'($urandom_range(0, 1));
        cnt_w = CntWidth'(1400);
      end
      6: begin
        cnt_w = CntWidth'($urandom_range(0, 1));
        len_w = LenWidth'($urandom_range(700, 790));
      end
      7: begin
        len_w = LenWidth'($urandom_range(100, 200));
        cnt_w = CntWidth'(1400 / len_w);
      end
      default: begin
        len_w = LenWidth'($urandom_range(2, 48));
        cnt_w = CntWidth'(1400 / len_w);
      end
    endcase
    write_register(CfgLineLength, CfgDataWidth'(len_w));
    write_register(CfgLineCount, CfgDataWidth'(cnt_w));
    write_register(CfgFindMinima, CfgDataWidth'($urandom_range(0, 1)));
  endtask

  // Field extremes, ties and early drain ticks at the head of the image
  task automatic test_directed_samples();
    sample_t corner [18];
    corner = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001, 16'sh7fff,
               16'sh8000, 16'sh0005, 16'sh0005, 16'sh0005, 16'sh0005, 16'sh0005,
               16'sh0005, -16'sh0007, -16'sh0007, -16'sh0007, 16'sh0000, 16'sh0000};
    // a drain before any sample must be dropped
    send_request(KindDrain, 16'sh7fff);
    foreach (corner[i]) begin
      if (stream_pos >= image_size()) break;
      send_request(KindSample, corner[i]);
      if (i == 4 && stream_pos < image_size()) send_request(KindDrain, 16'sh8000);
    end
  endtask

  // Random image content up to stream position stop, with stray drain ticks
  task automatic test_random_samples(int unsigned stop);
    while (stream_pos < stop) begin
      if ($urandom_range(0, 31) == 0) send_request(KindDrain, random_pixel());
      else send_request(KindSample, random_pixel());
    end
  endtask

  // Stall the result side for a long stretch while requests keep coming,
  // so the result register fills and the input stalls behind it; past the
  // image, drain ticks keep the flags coming
  task automatic test_backpressure();
    bit keep;
    keep        = pix_idle_on;
    pix_idle_on = 1'b0;
    rx_hold     = 200;
    repeat (40) begin
      if (stream_pos < image_size()) send_request(KindSample, random_pixel());
      else if (flags_out < image_size()) send_request(KindDrain, random_pixel());
    end
    pix_idle_on = keep;
  endtask

  // Hold the source mid-image until every predicted flag has left
  task automatic test_pause();
    settle_stream(1);
  endtask

  // Push the pending flags out; go quiet on both sides near the end
  task automatic test_drain();
    while (flags_out < image_size()) begin
      if (image_size() - flags_out <= 64) begin
        pix_idle_on = 1'b0;
        res_idle_on = 1'b0;
      end
      send_request(KindDrain, random_pixel());
    end
  endtask

  // Samples and drains after the final flag must all be dropped
  task automatic test_ignored_requests();
    pix_idle_on = 1'b0;
    res_idle_on = 1'b0;
    repeat (12) send_request($urandom_range(0, 1) ? KindDrain : KindSample, random_pixel());
    settle_stream(8);
  endtask

  // Walk the registers through their extremes while idle, land on a
  // one-pixel geometry that keeps the finished block idle, then poke it
  task automatic test_config_sweep();
    write_register(CfgLineLength, CfgDataWidth'(2047));
    write_register(CfgLineCount, CfgDataWidth'(65535));
    write_register(CfgFindMinima, CfgDataWidth'(!cfg_min));
    write_register(CfgLineLength, CfgDataWidth'(MaxLineLength));
    write_register(CfgLineCount, CfgDataWidth'(1));
    write_register(CfgFindMinima, CfgDataWidth'(!cfg_min));
    write_register(CfgLineLength, CfgDataWidth'(0));
    write_register(CfgLineCount, CfgDataWidth'(0));
    repeat (10) send_request($urandom_range(0, 1) ? KindDrain : KindSample, random_pixel());
  endtask

  // Result sink: random ready bursts, plus one long hold on request
  initial begin : result_sink
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold != 0) begin
        res_if.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk_i);
        rx_hold = 0;
        res_if.ready <= 1'b1;
      end else if (res_idle_on && $urandom_range(0, 11) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Compare each taken flag with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_flags.size() == 0) begin
        $display("%0t: unexpected result: expected none, got is_extreme=%0b last=%0b",
                 $time, res_if.is_extreme, res_if.last);
        mismatches++;
      end else begin
        oldest_flag = pending_flags.pop_front();
        if (res_if.is_extreme !== oldest_flag.is_extreme) begin
          $display("%0t: is_extreme mismatch: expected %0b, got %0b",
                   $time, oldest_flag.is_extreme, res_if.is_extreme);
          mismatches++;
        end
        if (res_if.last !== oldest_flag.last) begin
          $display("%0t: last mismatch: expected %0b, got %0b",
                   $time, oldest_flag.last, res_if.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= CfgLineLength;
    cfg_if.data   <= '0;
    pix_if.valid  <= 1'b0;
    pix_if.kind   <= KindSample;
    pix_if.sample <= '0;
    // line stores and tile read as zero until written
    for (int i = 0; i < MaxLineLength; i++) begin
      prev2_line[i] = '0;
      prev1_line[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) tile[i][k] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_configure_image();
    test_directed_samples();
    test_random_samples(image_size() * 2 / 5);
    test_pause();
    test_random_samples(image_size());
    test_backpressure();
    test_drain();
    test_ignored_requests();
    test_config_sweep();
    settle_stream(20);

    if (mismatches == 0) begin
      $display("** window_local_extremum_map_core: PASSED **");
    end else begin
      $display("** window_local_extremum_map_core: FAILED **");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("** window_local_extremum_map_core: FAILED **");
    $finish;
  end

endmodule

@@ window_local_extremum_map_core.f @@
rtl/wlem_pkg.sv
rtl/wlem_if.sv
rtl/window_local_extremum_map_core.sv
tb/window_local_extremum_map_core_tb.sv
